FILE: rtl/core/mftach_pkg.sv
// Shared constants and controller/datapath command and status types for the
// multi-fan tach speed meter. No dependencies.
package mftach_pkg;

    localparam int NUM_SLOTS_DEF  = 7;
    localparam int COUNT_BITS_DEF = 13;

    localparam int LEVEL_W   = 7;
    localparam int FAN_W     = 3;
    localparam int SPEED_W   = 16;
    localparam int TIMEOUT_W = 12;
    localparam int PHASE_W   = 4;

    localparam int NUM_PHASES = 8;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 12'd1000;

    localparam int DIV_BITS = 20;
    localparam logic [DIV_BITS-1:0] SPEED_NUMERATOR = 20'd600000;
    localparam int AVG_DIVISOR = 7;

    // floor(sum / 7) = (sum * RECIP7) >> RECIP7_SHIFT for every reachable sum
    localparam int RECIP7_W     = 20;
    localparam int RECIP7_SHIFT = 22;
    localparam logic [RECIP7_W-1:0] RECIP7 = 20'd599187;

    typedef struct packed {
        logic tick;
        logic end_take;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic end_phase;
        logic need_div;
    } t_dp_stat;

endpackage

FILE: rtl/core/mftach_ctrl.sv
// Controller for the multi-fan tach speed meter: sequences tick intake, the serial
// speed division and the result register. Uses mftach_pkg.
module mftach_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_tach_valid,
    input  logic                i_result_stall,
    input  mftach_pkg::t_dp_stat i_stat,
    output mftach_pkg::t_dp_cmd  o_cmd,
    output logic                o_tach_stall,
    output logic                o_result_valid
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    localparam int ITER_W = $clog2(mftach_pkg::DIV_BITS);
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(mftach_pkg::DIV_BITS - 1);

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [ITER_W-1:0] r_iter;
    logic [ITER_W-1:0] n_iter;
    logic              r_out_valid;
    logic              n_out_valid;
    logic              accept;
    logic              out_free;

    assign accept   = i_tach_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_result_stall;

    always_comb begin
        n_state        = r_state;
        n_iter         = r_iter;
        o_cmd.tick     = 1'b0;
        o_cmd.end_take = 1'b0;
        o_cmd.div_step = 1'b0;
        o_cmd.out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_stat.end_phase) begin
                        o_cmd.end_take = 1'b1;
                        n_iter = '0;
                        n_state = i_stat.need_div ? S_DIV : S_OUT;
                    end else begin
                        o_cmd.tick = 1'b1;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_iter = r_iter + 1'b1;
                if (r_iter == ITER_LAST) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = o_cmd.out_load || (r_out_valid && i_result_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_iter      <= n_iter;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_tach_stall   = (r_state != S_IDLE);
    assign o_result_valid = r_out_valid;

endmodule

FILE: rtl/core/mftach_dp.sv
// Datapath for the multi-fan tach speed meter: phase tracking, tick counting,
// reciprocal divide by 7, serial speed divider and result register. Uses mftach_pkg.
module mftach_dp #(
    parameter int NUM_SLOTS  = mftach_pkg::NUM_SLOTS_DEF,
    parameter int COUNT_BITS = mftach_pkg::COUNT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mftach_pkg::t_dp_cmd                  i_cmd,
    output mftach_pkg::t_dp_stat                 o_stat,
    input  logic [mftach_pkg::LEVEL_W-1:0]       i_tach_levels,
    input  logic                                i_cfg_valid,
    input  logic [mftach_pkg::TIMEOUT_W-1:0]     i_cfg_phase_timeout,
    output logic [mftach_pkg::FAN_W-1:0]         o_fan_index,
    output logic [mftach_pkg::SPEED_W-1:0]       o_speed,
    output logic                                o_speed_valid,
    output logic                                o_cycle_done
);

    localparam int SUM_W = COUNT_BITS + 3;
    localparam int CMP_W = (COUNT_BITS > mftach_pkg::TIMEOUT_W) ?
                           COUNT_BITS : mftach_pkg::TIMEOUT_W;
    localparam int DB    = mftach_pkg::DIV_BITS;
    localparam int FW    = mftach_pkg::FAN_W;
    localparam int PW    = mftach_pkg::PHASE_W;
    localparam int PROD_W = SUM_W + mftach_pkg::RECIP7_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [FW-1:0] LAST_SLOT = FW'(NUM_SLOTS - 1);
    localparam logic [PW-1:0] PHASE_END = PW'(mftach_pkg::NUM_PHASES);
    localparam logic [PW-1:0] PHASE_LAST = PW'(mftach_pkg::NUM_PHASES - 1);

    logic [mftach_pkg::TIMEOUT_W-1:0] r_timeout;
    logic [PW-1:0]         r_phase;
    logic [PW-1:0]         n_phase;
    logic [FW-1:0]         r_fan;
    logic [FW-1:0]         n_fan;
    logic [COUNT_BITS-1:0] r_count;
    logic [COUNT_BITS-1:0] n_count;
    logic [SUM_W-1:0]      r_sum;
    logic [SUM_W-1:0]      n_sum;
    logic                  r_seen_last;
    logic                  n_seen_last;

    logic [FW-1:0]         r_pend_fan;
    logic                  r_pend_valid;
    logic                  r_pend_done;

    logic [SUM_W-1:0]      r_div_rem;
    logic [DB-1:0]         r_div_quo;
    logic [SUM_W-1:0]      r_div_den;
    logic [SUM_W:0]        div_trial;
    logic                  div_fit;
    logic [PROD_W-1:0]     avg_prod;

    logic                  end_phase;
    logic                  last_slot;
    logic                  level_high;
    logic                  not_sat;
    logic [COUNT_BITS-1:0] count_inc;
    logic                  timed_out;
    logic                  advance;

    assign end_phase  = r_phase >= PHASE_END;
    assign last_slot  = r_fan >= LAST_SLOT;
    assign level_high = (r_fan < FW'(mftach_pkg::LEVEL_W)) ? i_tach_levels[r_fan] : 1'b0;
    assign not_sat    = r_count != COUNT_MAX;
    assign count_inc  = not_sat ? r_count + 1'b1 : r_count;
    assign timed_out  = CMP_W'(count_inc) > CMP_W'(r_timeout);
    assign advance    = r_phase[0] ? !level_high : level_high;

    assign o_stat.end_phase = end_phase;
    assign o_stat.need_div  = !last_slot && r_seen_last;

    always_comb begin
        n_phase     = r_phase;
        n_fan       = r_fan;
        n_count     = r_count;
        n_sum       = r_sum;
        n_seen_last = r_seen_last;
        if (i_cmd.tick) begin
            n_sum = not_sat ? r_sum + 1'b1 : r_sum;
            if (r_phase == PHASE_LAST) begin
                n_seen_last = 1'b1;
            end
            if (timed_out) begin
                n_phase = PHASE_END;
                n_count = count_inc;
            end else if (advance) begin
                n_phase = r_phase + 1'b1;
                n_count = '0;
            end else begin
                n_count = count_inc;
            end
        end else if (i_cmd.end_take) begin
            n_phase     = '0;
            n_count     = '0;
            n_sum       = '0;
            n_seen_last = 1'b0;
            n_fan       = last_slot ? '0 : r_fan + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= mftach_pkg::TIMEOUT_RESET;
            r_phase     <= '0;
            r_fan       <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_seen_last <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_timeout <= i_cfg_phase_timeout;
            end
            r_phase     <= n_phase;
            r_fan       <= n_fan;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_seen_last <= n_seen_last;
        end
    end

    assign avg_prod  = PROD_W'(r_sum) * PROD_W'(mftach_pkg::RECIP7);
    assign div_trial = {r_div_rem, r_div_quo[DB-1]};
    assign div_fit   = div_trial >= {1'b0, r_div_den};

    always_ff @(posedge i_clk) begin
        if (i_cmd.end_take) begin
            r_pend_fan   <= r_fan;
            r_pend_valid <= !last_slot && r_seen_last;
            r_pend_done  <= last_slot;
            r_div_rem    <= '0;
            r_div_quo    <= mftach_pkg::SPEED_NUMERATOR;
            r_div_den    <= {avg_prod[mftach_pkg::RECIP7_SHIFT +: SUM_W-2], 2'b00};
        end else if (i_cmd.div_step) begin
            r_div_rem    <= div_fit ? SUM_W'(div_trial - {1'b0, r_div_den})
                                    : div_trial[SUM_W-1:0];
            r_div_quo    <= {r_div_quo[DB-2:0], div_fit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_fan_index   <= r_pend_fan;
            o_speed       <= r_pend_valid ? r_div_quo[mftach_pkg::SPEED_W-1:0] : '0;
            o_speed_valid <= r_pend_valid;
            o_cycle_done  <= r_pend_done;
        end
    end

endmodule

FILE: rtl/core/multi_fan_tach_speed_meter_core.sv
// Top level of the multi-fan tach speed meter: controller plus datapath.
// Depends on mftach_pkg, mftach_ctrl and mftach_dp.
//
// Usage: each tach request is one timer tick carrying the sampled levels of
// the tach lines (bit n is fan n). Fans are measured one at a time, round
// robin over NUM_SLOTS slots; a measurement walks eight alternating phases.
// An ordinary tick produces no result; ticks can arrive back to back while
// tach input is not stalled. The tick after a measurement ends yields one result
// request: fan index, speed = 600000 / ((sum / 7) * 4) in 16 bits, a valid
// flag and a round-done flag on the last slot.
// After that end tick is taken, a speed result needs sum / 7 by reciprocal
// multiply on the take edge, then a 20-step restoring division, then the
// output load; a result without a speed goes straight to the output load.
// Tach input is stalled during that time.
// The result sits in an output register; a stalled receiver holds it, and
// further ordinary ticks are still taken meanwhile. A new end tick waits in
// the final stage until the register frees.
// The config channel is always ready and writes phase_timeout.
// Reset (synchronous, active low) returns to slot 0, phase 0, counts zero and
// phase_timeout 1000; no clearing pass is needed.
module multi_fan_tach_speed_meter_core #(
    parameter int NUM_SLOTS  = mftach_pkg::NUM_SLOTS_DEF,
    parameter int COUNT_BITS = mftach_pkg::COUNT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_tach_valid,
    output logic                                o_tach_stall,
    input  logic [mftach_pkg::LEVEL_W-1:0]       i_tach_levels,
    output logic                                o_result_valid,
    input  logic                                i_result_stall,
    output logic [mftach_pkg::FAN_W-1:0]         o_fan_index,
    output logic [mftach_pkg::SPEED_W-1:0]       o_speed,
    output logic                                o_speed_valid,
    output logic                                o_cycle_done,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mftach_pkg::TIMEOUT_W-1:0]     i_cfg_phase_timeout
);

    mftach_pkg::t_dp_cmd  cmd;
    mftach_pkg::t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    mftach_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tach_valid   (i_tach_valid),
        .i_result_stall (i_result_stall),
        .i_stat         (stat),
        .o_cmd          (cmd),
        .o_tach_stall   (o_tach_stall),
        .o_result_valid (o_result_valid)
    );

    mftach_dp #(
        .NUM_SLOTS  (NUM_SLOTS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .i_tach_levels       (i_tach_levels),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_phase_timeout (i_cfg_phase_timeout),
        .o_fan_index         (o_fan_index),
        .o_speed             (o_speed),
        .o_speed_valid       (o_speed_valid),
        .o_cycle_done        (o_cycle_done)
    );

endmodule
